### rtl/core/ctbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table package
// Shared types and constants for the connection table engine: operation
// codes, link state codes, field widths and the scan result record.
// ----------------------------------------------------------------------------
package ctbl_pkg;

    localparam int DATA_W  = 32;   // stamp and duration width
    localparam int KEY_W   = 32;   // device address width on the request word
    localparam int USED_W  = 5;    // width of the reported entry count

    // Link state of a table entry.
    localparam logic NOTCONNECTED = 1'b0;
    localparam logic ACTIVE       = 1'b1;

    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2
    } t_kind;

    // Outcome of one pass over the allocated part of the table.
    typedef struct packed {
        logic              hit;         // an entry with the key was found
        logic              idle_found;  // a not-connected entry was found
        logic              hit_active;  // link state of the matching entry
        logic [DATA_W-1:0] hit_stamp;
        logic [DATA_W-1:0] hit_dur;
    } t_scan_res;

endpackage
`default_nettype wire

### rtl/core/ctbl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table channel interfaces
// Request and response channels with a valid/ready handshake; a word moves
// at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ctbl_req_if
    import ctbl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] duration;

    modport source (output valid, kind, key, stamp, duration, input ready);
    modport sink   (input valid, kind, key, stamp, duration, output ready);
endinterface

interface ctbl_rsp_if
    import ctbl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic              found;
    logic              link_state;
    logic [DATA_W-1:0] stamp_out;
    logic [DATA_W-1:0] duration_out;
    logic [USED_W-1:0] used_entries;

    modport source (output valid, ok, found, link_state, stamp_out, duration_out,
                    used_entries, input ready);
    modport sink   (input valid, ok, found, link_state, stamp_out, duration_out,
                    used_entries, output ready);
endinterface
`default_nettype wire

### rtl/core/ctbl_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table memory
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ctbl_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 97
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/ctbl_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table scanner
// Walks the allocated entries one read per cycle and records the lowest
// entry with a matching key and the lowest not-connected entry.
// ----------------------------------------------------------------------------
module ctbl_scan
    import ctbl_pkg::*;
#(
    parameter int AW = 4,
    parameter int CW = 5,
    parameter int KW = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [CW-1:0]          i_count,
    input  wire logic [KW-1:0]          i_key,
    input  wire logic [KW+2*DATA_W:0]   i_rdata,
    output logic                        o_re,
    output logic      [AW-1:0]          o_raddr,
    output logic                        o_done,
    output t_scan_res                   o_res,
    output logic      [AW-1:0]          o_hit_idx,
    output logic      [AW-1:0]          o_idle_idx
);

    localparam int W = KW + 2 * DATA_W + 1;

    logic            r_busy, n_busy;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_pend_idx, n_pend_idx;
    t_scan_res       r_res, n_res;
    logic [AW-1:0]   r_hit_idx, n_hit_idx;
    logic [AW-1:0]   r_idle_idx, n_idle_idx;

    logic [KW-1:0]     rd_key;
    logic [DATA_W-1:0] rd_stamp;
    logic [DATA_W-1:0] rd_dur;
    logic              rd_act;
    logic              issue;

    assign rd_key   = i_rdata[W-1 -: KW];
    assign rd_stamp = i_rdata[2*DATA_W -: DATA_W];
    assign rd_dur   = i_rdata[DATA_W -: DATA_W];
    assign rd_act   = i_rdata[0];

    assign issue   = r_busy && (r_idx != i_count);
    assign o_re    = issue;
    assign o_raddr = r_idx[AW-1:0];
    assign o_done  = r_busy && (r_idx == i_count) && !r_pend;

    always_comb begin
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_pend     = issue;
        n_pend_idx = r_idx[AW-1:0];
        n_res      = r_res;
        n_hit_idx  = r_hit_idx;
        n_idle_idx = r_idle_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_pend = 1'b0;
            n_res  = '0;
        end else begin
            if (issue) begin
                n_idx = CW'(r_idx + 1'b1);
            end
            if (o_done) begin
                n_busy = 1'b0;
            end
            // Data for the read issued last cycle is on the memory output now.
            if (r_pend && !r_res.hit && (rd_key == i_key)) begin
                n_res.hit        = 1'b1;
                n_res.hit_active = rd_act;
                n_res.hit_stamp  = rd_stamp;
                n_res.hit_dur    = rd_dur;
                n_hit_idx        = r_pend_idx;
            end
            if (r_pend && !r_res.idle_found && (rd_act == NOTCONNECTED)) begin
                n_res.idle_found = 1'b1;
                n_idle_idx       = r_pend_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_idx  <= '0;
            r_res  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_idx  <= n_idx;
            r_res  <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_hit_idx  <= n_hit_idx;
        r_idle_idx <= n_idle_idx;
    end

    assign o_res      = r_res;
    assign o_hit_idx  = r_hit_idx;
    assign o_idle_idx = r_idle_idx;

endmodule
`default_nettype wire

### rtl/core/connection_table_engine.sv
`default_nettype none
// One operation at a time: a new request word is taken only after the
// response word of the last one has left. The table scan makes one read per
// cycle over the allocated entries (none when the table is empty), and the
// response word is registered in the decide state.
// Reset clears the control state and the allocated count; the table memory
// itself is not cleared, as entries at or above the count are never read.
// ----------------------------------------------------------------------------
// Connection table engine
// A flat table of connection entries keyed by device address, supporting
// put, remove and lookup through a scan of one synchronous memory followed
// by at most one read-modify-write back.
// ----------------------------------------------------------------------------
module connection_table_engine
    import ctbl_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ctbl_req_if.sink    i_req,
    ctbl_rsp_if.source  o_rsp
);

    // Only the low KEY_BITS of an address are kept, and the address on the
    // request word is KEY_W wide, so the stored key never needs more.
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int W  = KW + 2 * DATA_W + 1;

    // One-hot sequencer: wait for a word, scan, write back, present result.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;

    // The accepted request word is held for the whole operation.
    logic [1:0]        r_kind;
    logic [KW-1:0]     r_key;
    logic [DATA_W-1:0] r_stamp;
    logic [DATA_W-1:0] r_dur;

    // Response register, loaded in the write-back cycle.
    logic              r_ok, n_ok;
    logic              r_found, n_found;
    logic              r_link, n_link;
    logic [DATA_W-1:0] r_stamp_o, n_stamp_o;
    logic [DATA_W-1:0] r_dur_o, n_dur_o;
    logic [USED_W-1:0] r_used;

    logic              req_acc;
    logic              scan_done;
    t_scan_res         scan_res;
    logic [AW-1:0]     hit_idx, idle_idx;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [W-1:0]      mem_rdata;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [W-1:0]      wr_data;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    ctbl_scan #(
        .AW (AW),
        .CW (CW),
        .KW (KW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (req_acc),
        .i_count    (r_count),
        .i_key      (r_key),
        .i_rdata    (mem_rdata),
        .o_re       (mem_re),
        .o_raddr    (mem_raddr),
        .o_done     (scan_done),
        .o_res      (scan_res),
        .o_hit_idx  (hit_idx),
        .o_idle_idx (idle_idx)
    );

    // The write-back happens in the decide cycle, after the last read of the
    // scan has returned, and the next scan starts only after the response
    // word has left, so a read never overlaps a write to the same entry.
    ctbl_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .W     (W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en && (r_state == S_DECIDE)),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decision on the scan outcome. The lowest matching entry takes
    // priority; without one, a put reuses the lowest not-connected entry
    // and only then appends at the end of the allocated region.
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = hit_idx;
        wr_data   = {r_key, r_stamp, r_dur, ACTIVE};
        n_count   = r_count;
        n_ok      = 1'b0;
        n_found   = 1'b0;
        n_link    = NOTCONNECTED;
        n_stamp_o = '0;
        n_dur_o   = '0;
        unique case (t_kind'(r_kind))
            KIND_PUT: begin
                if (scan_res.hit) begin
                    n_found = 1'b1;
                    if (scan_res.hit_active == NOTCONNECTED) begin
                        wr_en     = 1'b1;
                        n_ok      = 1'b1;
                        n_link    = ACTIVE;
                        n_stamp_o = r_stamp;
                        n_dur_o   = r_dur;
                    end else begin
                        // Still active: the entry is reported unchanged.
                        n_link    = scan_res.hit_active;
                        n_stamp_o = scan_res.hit_stamp;
                        n_dur_o   = scan_res.hit_dur;
                    end
                end else if (scan_res.idle_found || (r_count < CW'(ENTRIES))) begin
                    wr_en     = 1'b1;
                    wr_addr   = scan_res.idle_found ? idle_idx : r_count[AW-1:0];
                    n_count   = scan_res.idle_found ? r_count : CW'(r_count + 1'b1);
                    n_ok      = 1'b1;
                    n_found   = 1'b1;
                    n_link    = ACTIVE;
                    n_stamp_o = r_stamp;
                    n_dur_o   = r_dur;
                end
            end
            KIND_REMOVE: begin
                if (scan_res.hit) begin
                    wr_en     = 1'b1;
                    wr_data   = {r_key, scan_res.hit_stamp, scan_res.hit_dur,
                                 NOTCONNECTED};
                    n_ok      = 1'b1;
                    n_found   = 1'b1;
                    n_stamp_o = scan_res.hit_stamp;
                    n_dur_o   = scan_res.hit_dur;
                end
            end
            KIND_LOOKUP: begin
                if (scan_res.hit) begin
                    n_ok      = 1'b1;
                    n_found   = 1'b1;
                    n_link    = scan_res.hit_active;
                    n_stamp_o = scan_res.hit_stamp;
                    n_dur_o   = scan_res.hit_dur;
                end
            end
            default: begin
                // Unused operation code: nothing changes, all fields but the entry count zero.
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (req_acc)     n_state = S_SCAN;
            S_SCAN:   if (scan_done)   n_state = S_DECIDE;
            S_DECIDE:                  n_state = S_RESP;
            S_RESP:   if (o_rsp.ready) n_state = S_IDLE;
            default:                   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind  <= i_req.kind;
            r_key   <= i_req.key[KW-1:0];
            r_stamp <= i_req.stamp;
            r_dur   <= i_req.duration;
        end
        if (r_state == S_DECIDE) begin
            r_ok      <= n_ok;
            r_found   <= n_found;
            r_link    <= n_link;
            r_stamp_o <= n_stamp_o;
            r_dur_o   <= n_dur_o;
            r_used    <= USED_W'(n_count);
        end
    end

    assign o_rsp.valid        = (r_state == S_RESP);
    assign o_rsp.ok           = r_ok;
    assign o_rsp.found        = r_found;
    assign o_rsp.link_state   = r_link;
    assign o_rsp.stamp_out    = r_stamp_o;
    assign o_rsp.duration_out = r_dur_o;
    assign o_rsp.used_entries = r_used;

    // The allocated count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("allocated count beyond table depth");

    // The count only ever grows, and by one entry at a time.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == CW'($past(r_count) + 1'b1)))
        else $error("allocated count changed by other than one");

    // A new request word is never taken while a response word is pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while response pending");

    // A successful put always leaves the entry active.
    a_put_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && r_ok && (r_kind == KIND_PUT) |-> (r_link == ACTIVE) && r_found)
        else $error("successful put did not report an active entry");

endmodule
`default_nettype wire

### verif/tb_connection_table_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Connection table engine testbench
// Drives put, remove, lookup and unused operation words into the engine and
// checks every response word against a model of the flat table that this
// bench keeps itself, or against the word a directed row gives. A short directed table covers the field extremes and
// the failure cases, then random traffic over a small pool of addresses
// runs through four idling phases on both channels.
// ----------------------------------------------------------------------------
module tb_connection_table_engine;
    import ctbl_pkg::*;

    localparam int TBL_ENTRIES     = 16;
    localparam int ADDR_BITS       = 32;
    localparam int ITEMS_PER_PHASE = 256;
    localparam int POOL_SIZE       = 24;

    // The request kind field is two bits wide; the one code the engine does
    // not define must still be exercised.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef struct packed {
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] duration;
    } t_link_req;

    typedef struct packed {
        logic              ok;
        logic              found;
        logic              link_state;
        logic [DATA_W-1:0] stamp_out;
        logic [DATA_W-1:0] duration_out;
        logic [USED_W-1:0] used_entries;
    } t_link_rsp;

    // One row of the directed table. Where typed is set, the response is
    // taken from the row rather than from the table model.
    typedef struct packed {
        t_link_req req;
        logic      typed;
        t_link_rsp rsp;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    ctbl_req_if req_if ();
    ctbl_rsp_if rsp_if ();

    connection_table_engine #(
        .ENTRIES  (TBL_ENTRIES),
        .KEY_BITS (ADDR_BITS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Model copy of the connection table.
    logic [KEY_W-1:0]  tbl_key   [TBL_ENTRIES];
    logic [DATA_W-1:0] tbl_stamp [TBL_ENTRIES];
    logic [DATA_W-1:0] tbl_dur   [TBL_ENTRIES];
    logic              tbl_state [TBL_ENTRIES];
    int                tbl_count = 0;

    t_link_rsp         pending_rsp [$];
    t_dir_row          dir_rows [$];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    int mismatch_count = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;

    t_link_rsp got_word;
    t_link_rsp want_word;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t mismatch on %0s: got %h, wanted %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void fill_entry(input int slot, input t_link_req rq);
        tbl_key[slot]   = rq.key;
        tbl_stamp[slot] = rq.stamp;
        tbl_dur[slot]   = rq.duration;
        tbl_state[slot] = ACTIVE;
    endfunction

    // Applies one operation to the model table and gives the response word
    // the engine should return for it.
    function automatic t_link_rsp predict_link_op(input t_link_req rq);
        t_link_rsp r;
        int        hit;
        int        idle;
        r    = '0;
        hit  = -1;
        idle = -1;
        if (rq.kind != KIND_UNUSED) begin
            // Walk downwards so that the lowest matching slot is kept.
            for (int i = tbl_count - 1; i >= 0; i--) begin
                if (tbl_key[i] == rq.key)
                    hit = i;
            end
        end
        case (rq.kind)
            KIND_PUT: begin
                if (hit >= 0) begin
                    if (tbl_state[hit] == NOTCONNECTED) begin
                        fill_entry(hit, rq);
                        r.ok = 1'b1;
                    end
                end else begin
                    for (int i = tbl_count - 1; i >= 0; i--) begin
                        if (tbl_state[i] == NOTCONNECTED)
                            idle = i;
                    end
                    if (idle >= 0) begin
                        fill_entry(idle, rq);
                        hit  = idle;
                        r.ok = 1'b1;
                    end else if (tbl_count < TBL_ENTRIES) begin
                        hit = tbl_count;
                        fill_entry(tbl_count, rq);
                        tbl_count++;
                        r.ok = 1'b1;
                    end
                end
            end
            KIND_REMOVE: begin
                if (hit >= 0) begin
                    tbl_state[hit] = NOTCONNECTED;
                    r.ok = 1'b1;
                end
            end
            KIND_LOOKUP: begin
                r.ok = (hit >= 0);
            end
            default: begin
                hit = -1;
            end
        endcase
        if (hit >= 0) begin
            r.found        = 1'b1;
            r.link_state   = tbl_state[hit];
            r.stamp_out    = tbl_stamp[hit];
            r.duration_out = tbl_dur[hit];
        end
        r.used_entries = USED_W'(tbl_count);
        return r;
    endfunction

    function automatic t_link_req mk_req(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                         input logic [DATA_W-1:0] st,
                                         input logic [DATA_W-1:0] du);
        t_link_req rq;
        rq.kind     = kind;
        rq.key      = key;
        rq.stamp    = st;
        rq.duration = du;
        return rq;
    endfunction

    function automatic void add_row(input t_link_req rq);
        t_dir_row row;
        row       = '0;
        row.req   = rq;
        row.typed = 1'b0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input t_link_req rq, input logic ok, input logic found,
                                      input logic link, input logic [DATA_W-1:0] so,
                                      input logic [DATA_W-1:0] dout,
                                      input logic [USED_W-1:0] used);
        t_dir_row row;
        row.req   = rq;
        row.typed = 1'b1;
        row.rsp   = '{ok: ok, found: found, link_state: link, stamp_out: so,
                      duration_out: dout, used_entries: used};
        dir_rows.push_back(row);
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return ALL_ONES;
        return $urandom();
    endfunction

    // Mostly addresses from the pool, so that puts, removes and lookups keep
    // meeting each other in the table; now and then a fresh random address.
    function automatic t_link_req random_op();
        t_link_req rq;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 40)
            rq.kind = KIND_PUT;
        else if (pick < 62)
            rq.kind = KIND_REMOVE;
        else if (pick < 95)
            rq.kind = KIND_LOOKUP;
        else
            rq.kind = KIND_UNUSED;
        if ($urandom_range(99) < 85)
            rq.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            rq.key = $urandom();
        rq.stamp    = rand_data();
        rq.duration = rand_data();
        return rq;
    endfunction

    // Offers one request word, idling first at the given rate, and returns
    // just after the edge at which the engine takes it. Valid is only lowered
    // when a gap is inserted, so back-to-back words keep it high.
    task automatic drive_word(input t_link_req rq, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.kind     <= rq.kind;
        req_if.key      <= rq.key;
        req_if.stamp    <= rq.stamp;
        req_if.duration <= rq.duration;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Response side: stalls at the current rate and checks each word taken
    // against the oldest outstanding prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_word = '{ok: rsp_if.ok, found: rsp_if.found,
                             link_state: rsp_if.link_state, stamp_out: rsp_if.stamp_out,
                             duration_out: rsp_if.duration_out,
                             used_entries: rsp_if.used_entries};
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected response word", got_word.stamp_out, '0);
                end else begin
                    want_word = pending_rsp.pop_front();
                    if (got_word.ok !== want_word.ok)
                        report_mismatch("ok", DATA_W'(got_word.ok), DATA_W'(want_word.ok));
                    if (got_word.found !== want_word.found)
                        report_mismatch("found", DATA_W'(got_word.found),
                                        DATA_W'(want_word.found));
                    if (got_word.link_state !== want_word.link_state)
                        report_mismatch("link_state", DATA_W'(got_word.link_state),
                                        DATA_W'(want_word.link_state));
                    if (got_word.stamp_out !== want_word.stamp_out)
                        report_mismatch("stamp_out", got_word.stamp_out, want_word.stamp_out);
                    if (got_word.duration_out !== want_word.duration_out)
                        report_mismatch("duration_out", got_word.duration_out,
                                        want_word.duration_out);
                    if (got_word.used_entries !== want_word.used_entries)
                        report_mismatch("used_entries", DATA_W'(got_word.used_entries),
                                        DATA_W'(want_word.used_entries));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        int        phase_tx [4];
        int        phase_rx [4];
        t_link_rsp predicted;
        t_link_req rq;

        phase_tx = '{0, 85, 0, 32};
        phase_rx = '{0, 0, 85, 32};

        req_if.valid    <= 1'b0;
        req_if.kind     <= KIND_PUT;
        req_if.key      <= '0;
        req_if.stamp    <= '0;
        req_if.duration <= '0;
        rst_n           <= 1'b0;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            tbl_key[i]   = '0;
            tbl_stamp[i] = '0;
            tbl_dur[i]   = '0;
            tbl_state[i] = NOTCONNECTED;
        end

        // Empty table: absent addresses and the undefined kind.
        add_typed(mk_req(KIND_LOOKUP, '0, '0, '0), 1'b0, 1'b0, NOTCONNECTED, '0, '0, 5'd0);
        add_typed(mk_req(KIND_REMOVE, ALL_ONES, '0, '0), 1'b0, 1'b0, NOTCONNECTED,
                  '0, '0, 5'd0);
        add_typed(mk_req(KIND_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES),
                  1'b0, 1'b0, NOTCONNECTED, '0, '0, 5'd0);
        // Extremes of address, stamp and duration.
        add_typed(mk_req(KIND_PUT, '0, '0, '0), 1'b1, 1'b1, ACTIVE, '0, '0, 5'd1);
        add_typed(mk_req(KIND_PUT, ALL_ONES, ALL_ONES, ALL_ONES),
                  1'b1, 1'b1, ACTIVE, ALL_ONES, ALL_ONES, 5'd2);
        // Put on an active entry fails and reports it unchanged.
        add_typed(mk_req(KIND_PUT, '0, 32'd1, 32'd1), 1'b0, 1'b1, ACTIVE, '0, '0, 5'd2);
        // Remove twice: the second remove of a not-connected entry still succeeds.
        add_typed(mk_req(KIND_REMOVE, '0, '0, '0), 1'b1, 1'b1, NOTCONNECTED, '0, '0, 5'd2);
        add_typed(mk_req(KIND_REMOVE, '0, ALL_ONES, ALL_ONES), 1'b1, 1'b1, NOTCONNECTED,
                  '0, '0, 5'd2);
        // Reactivation of the same address, then reuse of a freed slot.
        add_row(mk_req(KIND_PUT, '0, 32'h0000_0055, 32'h0000_00AA));
        add_row(mk_req(KIND_REMOVE, ALL_ONES, '0, '0));
        add_row(mk_req(KIND_PUT, 32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        // Fill the table up to its last slot.
        for (int i = 2; i < TBL_ENTRIES; i++)
            add_row(mk_req(KIND_PUT, 32'h0000_0100 + i, 32'h1000_0000 + i, 32'h2000_0000 + i));
        // Put of a new address into a full table fails.
        add_typed(mk_req(KIND_PUT, 32'hDEAD_BEEF, 32'h1, 32'h2), 1'b0, 1'b0, NOTCONNECTED,
                  '0, '0, 5'd16);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            drive_word(dir_rows[i].req, 0);
            predicted = predict_link_op(dir_rows[i].req);
            pending_rsp.push_back(dir_rows[i].typed ? dir_rows[i].rsp : predicted);
        end

        // Pool of addresses: whatever the table holds now, plus a few strangers
        // so that puts keep hitting the full-table case.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < tbl_count) ? tbl_key[i] : KEY_W'($urandom());

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = phase_tx[ph];
            rx_stall_pct = phase_rx[ph];
            // Hold off until the engine has drained before each phase.
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while (pending_rsp.size() != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                rq = random_op();
                drive_word(rq, tx_idle_pct);
                pending_rsp.push_back(predict_link_op(rq));
            end
        end
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        // Leave room for any stray word behind the last one.
        repeat (2 * TBL_ENTRIES + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
